>>> design/pmc_pkg.sv
// shared types and constants of the pid move controller
// used by pmc_cfg_regs, pmc_core and pid_move_controller; no dependencies
package pmc_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_SUM_WIDTH    = 32;

  localparam int TARGET_WIDTH    = 16;
  localparam int MAX_ERR_WIDTH   = 17;
  localparam int GAIN_WIDTH      = 16;
  localparam int TIME_WIDTH      = 16;
  localparam int PERIOD_WIDTH    = 10;
  localparam int DRIVE_WIDTH     = 12;
  localparam int DRIVE_MAG_WIDTH = 11;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 17;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_ERR = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD  = 3'd6;

  localparam logic [MAX_ERR_WIDTH-1:0] MAX_ERR_RESET = 17'h1FFFF;
  localparam logic [PERIOD_WIDTH-1:0]  PERIOD_RESET  = 10'd15;

  // drive is Q12.4 percent: 100 % and 2.5 %
  localparam int DRIVE_LIMIT  = 1600;
  localparam int SETTLE_LIMIT = 40;
  // products carry 12 fraction bits, drive keeps 4
  localparam int FRAC_DROP    = 8;
  localparam int ROUND_BIAS   = 128;

  typedef struct packed {
    logic signed [TARGET_WIDTH-1:0] target_position;
    logic [MAX_ERR_WIDTH-1:0]       max_error;
    logic signed [GAIN_WIDTH-1:0]   gain_p;
    logic signed [GAIN_WIDTH-1:0]   gain_i;
    logic signed [GAIN_WIDTH-1:0]   gain_d;
    logic [TIME_WIDTH-1:0]          timeout_ms;
    logic [PERIOD_WIDTH-1:0]        period_ms;
  } pmc_cfg_t;

  typedef struct packed {
    logic                          has;
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          done_res;
    logic                          timed_out;
  } pmc_result_t;

endpackage

>>> design/pmc_cfg_regs.sv
// configuration register file of the pid move controller
// depends on pmc_pkg
module pmc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pmc_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [pmc_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
  output pmc_pkg::pmc_cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_position <= '0;
      cfg.max_error       <= pmc_pkg::MAX_ERR_RESET;
      cfg.gain_p          <= '0;
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.timeout_ms      <= '0;
      cfg.period_ms       <= pmc_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        pmc_pkg::REG_TARGET:  cfg.target_position <= wr_data[pmc_pkg::TARGET_WIDTH-1:0];
        pmc_pkg::REG_MAX_ERR: cfg.max_error       <= wr_data[pmc_pkg::MAX_ERR_WIDTH-1:0];
        pmc_pkg::REG_GAIN_P:  cfg.gain_p          <= wr_data[pmc_pkg::GAIN_WIDTH-1:0];
        pmc_pkg::REG_GAIN_I:  cfg.gain_i          <= wr_data[pmc_pkg::GAIN_WIDTH-1:0];
        pmc_pkg::REG_GAIN_D:  cfg.gain_d          <= wr_data[pmc_pkg::GAIN_WIDTH-1:0];
        pmc_pkg::REG_TIMEOUT: cfg.timeout_ms      <= wr_data[pmc_pkg::TIME_WIDTH-1:0];
        pmc_pkg::REG_PERIOD:  cfg.period_ms       <= wr_data[pmc_pkg::PERIOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/pmc_core.sv
// pid law, move state and timeout check for one registered sample
// depends on pmc_pkg
module pmc_core #(
  parameter int SAMPLE_WIDTH = pmc_pkg::DEF_SAMPLE_WIDTH,
  parameter int SUM_WIDTH    = pmc_pkg::DEF_SUM_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic signed [SAMPLE_WIDTH-1:0] position,
  input  logic                           start_req,
  input  pmc_pkg::pmc_cfg_t              cfg,
  output pmc_pkg::pmc_result_t           res
);

  localparam int PW  = (SAMPLE_WIDTH > pmc_pkg::TARGET_WIDTH) ? SAMPLE_WIDTH
                                                               : pmc_pkg::TARGET_WIDTH;
  localparam int EW  = PW + 1;
  localparam int DW  = EW + 1;
  localparam int SXW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
  localparam int MW  = (EW > pmc_pkg::MAX_ERR_WIDTH) ? EW : pmc_pkg::MAX_ERR_WIDTH;
  localparam int GW  = pmc_pkg::GAIN_WIDTH;
  localparam int AW  = (((GW + SUM_WIDTH) > (GW + DW)) ? (GW + SUM_WIDTH) : (GW + DW)) + 2;
  localparam int QW  = AW + 1 - pmc_pkg::FRAC_DROP;
  localparam int TW  = pmc_pkg::TIME_WIDTH;
  localparam int MGW = pmc_pkg::DRIVE_MAG_WIDTH;

  localparam logic signed [SUM_WIDTH-1:0] SUM_HI = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_LO = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic signed [SUM_WIDTH-1:0] error_sum, error_sum_next;
  logic signed [EW-1:0]        last_error, last_error_next;
  logic [TW-1:0]               elapsed_time, elapsed_time_next;
  logic                        running, running_next;

  logic signed [EW-1:0]        err;
  logic [EW-1:0]               err_mag;
  logic signed [SXW-1:0]       sum_raw;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [SUM_WIDTH-1:0] sum_new;
  logic                        sum_clear;
  logic signed [DW-1:0]        deriv;
  logic signed [GW+EW-1:0]     p_prod;
  logic signed [GW+SUM_WIDTH-1:0] i_prod;
  logic signed [GW+DW-1:0]     d_prod;
  logic signed [AW-1:0]        acc;
  logic                        acc_neg;
  logic [AW-1:0]               acc_mag;
  logic [AW:0]                 acc_round;
  logic [QW-1:0]               drive_q;
  logic [MGW-1:0]              drive_mag;
  logic signed [pmc_pkg::DRIVE_WIDTH-1:0] drive_val;
  logic                        settled;
  logic [TW:0]                 time_sum;
  logic [TW-1:0]               time_sat;
  logic                        time_up;

  // error path and saturating integral
  always_comb begin
    err       = EW'(cfg.target_position) - EW'(position);
    err_mag   = err[EW-1] ? $unsigned(-err) : $unsigned(err);
    sum_raw   = SXW'(error_sum) + SXW'(err);
    if (sum_raw > SXW'(SUM_HI)) begin
      sum_sat = SUM_HI;
    end else if (sum_raw < SXW'(SUM_LO)) begin
      sum_sat = SUM_LO;
    end else begin
      sum_sat = sum_raw[SUM_WIDTH-1:0];
    end
    sum_clear = (err == '0) || (MW'(err_mag) > MW'(cfg.max_error));
    sum_new   = sum_clear ? '0 : sum_sat;
    deriv     = DW'(err) - DW'(last_error);
  end

  // gains, rounding to Q12.4 (ties away from zero) and clamp
  always_comb begin
    p_prod    = cfg.gain_p * err;
    i_prod    = cfg.gain_i * sum_new;
    d_prod    = cfg.gain_d * deriv;
    acc       = AW'(p_prod) + AW'(i_prod) + AW'(d_prod);
    acc_neg   = acc[AW-1];
    acc_mag   = acc_neg ? $unsigned(-acc) : $unsigned(acc);
    acc_round = {1'b0, acc_mag} + (AW+1)'(pmc_pkg::ROUND_BIAS);
    drive_q   = acc_round[AW:pmc_pkg::FRAC_DROP];
    if (drive_q > QW'(pmc_pkg::DRIVE_LIMIT)) begin
      drive_mag = MGW'(pmc_pkg::DRIVE_LIMIT);
    end else begin
      drive_mag = drive_q[MGW-1:0];
    end
    drive_val = acc_neg ? -$signed({1'b0, drive_mag}) : $signed({1'b0, drive_mag});
    settled   = drive_mag <= MGW'(pmc_pkg::SETTLE_LIMIT);
  end

  // elapsed time saturates at all ones
  always_comb begin
    time_sum = {1'b0, elapsed_time} + (TW+1)'(cfg.period_ms);
    time_sat = time_sum[TW] ? '1 : time_sum[TW-1:0];
    time_up  = (cfg.timeout_ms != '0) && (time_sat > cfg.timeout_ms);
  end

  always_comb begin
    error_sum_next    = error_sum;
    last_error_next   = last_error;
    elapsed_time_next = elapsed_time;
    running_next      = running;
    res               = '0;
    if (start_req) begin
      error_sum_next    = '0;
      elapsed_time_next = '0;
      last_error_next   = err;
      running_next      = 1'b1;
    end else if (running) begin
      elapsed_time_next = time_sat;
      res.has           = 1'b1;
      res.done_res      = 1'b1;
      if (time_up) begin
        running_next  = 1'b0;
        res.timed_out = 1'b1;
      end else begin
        error_sum_next  = sum_new;
        last_error_next = err;
        res.drive       = drive_val;
        res.done_res    = settled;
        if (settled) begin
          running_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum    <= '0;
      last_error   <= '0;
      elapsed_time <= '0;
      running      <= 1'b0;
    end else if (step) begin
      error_sum    <= error_sum_next;
      last_error   <= last_error_next;
      elapsed_time <= elapsed_time_next;
      running      <= running_next;
    end
  end

endmodule

>>> design/pid_move_controller.sv
// pid move controller: samples in, drives out, one per cycle unless stalled
// channels: sample (valid/stall) carries position and start_req; result
// (valid/stall) carries drive, done_res and timed_out; cfg (valid/ready)
// writes the seven registers by index, always ready, acting at once.
// a sample marked start_req opens a move and gives no result; later samples
// each give one result until the move ends by settling or by timeout, and
// samples outside a move give nothing.
// path: an accepted item goes through the sample register, then through
// the pid update into the result register.
// throughput: one item per cycle unless a result waits under result_stall,
// set by the update loop through the integral and move state.
// stall: while a result waits under result_stall, one more sample is held
// in the sample register and sample_stall rises only when that is full.
// reset: synchronous, clears both stage valids, the move state and loads
// the register reset values; depends on pmc_pkg, pmc_cfg_regs, pmc_core
module pid_move_controller #(
  parameter int SAMPLE_WIDTH = pmc_pkg::DEF_SAMPLE_WIDTH,
  parameter int SUM_WIDTH    = pmc_pkg::DEF_SUM_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         position,
  input  logic                                   start_req,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [pmc_pkg::DRIVE_WIDTH-1:0] drive,
  output logic                                   done_res,
  output logic                                   timed_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pmc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [pmc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  logic                           s0_valid;
  logic signed [SAMPLE_WIDTH-1:0] s0_position;
  logic                           s0_start;
  logic                           out_ready;
  logic                           step;
  pmc_pkg::pmc_cfg_t              cfg;
  pmc_pkg::pmc_result_t           res;

  assign cfg_ready    = 1'b1;
  assign out_ready    = !result_valid || !result_stall;
  assign step         = s0_valid && out_ready;
  assign sample_stall = s0_valid && !out_ready;

  pmc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pmc_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .position  (s0_position),
    .start_req (s0_start),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!sample_stall) begin
      s0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      s0_position <= position;
      s0_start    <= start_req;
    end
  end

  // items that give no result leave no bubble in the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= step && res.has;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.has) begin
      drive     <= res.drive;
      done_res  <= res.done_res;
      timed_out <= res.timed_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && timed_out |-> done_res && (drive == '0))
    else $error("timeout result without done or with nonzero drive");

  a_busy_above_settle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !done_res |->
      (drive > $signed(12'(pmc_pkg::SETTLE_LIMIT))) ||
      (drive < -$signed(12'(pmc_pkg::SETTLE_LIMIT))))
    else $error("move left running with drive inside settle band");

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (drive <= $signed(12'(pmc_pkg::DRIVE_LIMIT))) &&
      (drive >= -$signed(12'(pmc_pkg::DRIVE_LIMIT))))
    else $error("drive outside full scale");

  a_stall_from_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without result backpressure");
`endif

endmodule

>>> tb/sv/pmc_checker.sv
`timescale 1ns / 1ps
// checker for the pid move controller: watches the sample, result and cfg channels,
// predicts each drive command from its own register copy and compares; depends on pmc_pkg
module pmc_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  input  logic                                   sample_stall,
  input  logic signed [pmc_pkg::DEF_SAMPLE_WIDTH-1:0] position,
  input  logic                                   start_req,
  input  logic                                   result_valid,
  input  logic                                   result_stall,
  input  logic signed [pmc_pkg::DRIVE_WIDTH-1:0] drive,
  input  logic                                   done_res,
  input  logic                                   timed_out,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [pmc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [pmc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  output int                                     fail_count,
  output int                                     pending
);
  import pmc_pkg::*;

  localparam longint SUM_HI = (longint'(1) <<< (DEF_SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned ELAPSED_MAX = 65535;

  typedef struct {
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          done_res;
    logic                          timed_out;
  } drive_cmd_t;

  drive_cmd_t drive_cmds_due[$];

  logic signed [TARGET_WIDTH-1:0] target;
  logic [MAX_ERR_WIDTH-1:0]       err_limit;
  logic signed [GAIN_WIDTH-1:0]   kp, ki, kd;
  logic [TIME_WIDTH-1:0]          time_limit;
  logic [PERIOD_WIDTH-1:0]        period;

  longint      integ;
  longint      prev_err;
  int unsigned elapsed_ms;
  bit          moving;
  int          mismatches = 0;

  task automatic apply_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] d);
    case (idx)
      REG_TARGET:  target = d[TARGET_WIDTH-1:0];
      REG_MAX_ERR: err_limit = d[MAX_ERR_WIDTH-1:0];
      REG_GAIN_P:  kp = d[GAIN_WIDTH-1:0];
      REG_GAIN_I:  ki = d[GAIN_WIDTH-1:0];
      REG_GAIN_D:  kd = d[GAIN_WIDTH-1:0];
      REG_TIMEOUT: time_limit = d[TIME_WIDTH-1:0];
      REG_PERIOD:  period = d[PERIOD_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // one pid update per sample; pushes the drive command it causes, if any
  task automatic pid_step(input logic signed [DEF_SAMPLE_WIDTH-1:0] pos, input logic st);
    longint     err;
    longint     deriv;
    longint     acc;
    longint     mag;
    drive_cmd_t cmd;
    err = longint'(target) - longint'(pos);
    if (st) begin
      integ = 0;
      elapsed_ms = 0;
      prev_err = err;
      moving = 1'b1;
    end else if (moving) begin
      elapsed_ms = elapsed_ms + period;
      if (elapsed_ms > ELAPSED_MAX) elapsed_ms = ELAPSED_MAX;
      if (time_limit != 0 && elapsed_ms > time_limit) begin
        moving = 1'b0;
        cmd.drive = '0;
        cmd.done_res = 1'b1;
        cmd.timed_out = 1'b1;
      end else begin
        integ = integ + err;
        if (integ > SUM_HI) integ = SUM_HI;
        else if (integ < SUM_LO) integ = SUM_LO;
        mag = (err < 0) ? -err : err;
        if (err == 0 || mag > longint'(err_limit)) integ = 0;
        deriv = err - prev_err;
        prev_err = err;
        acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
        // round half away from zero on the magnitude, then clamp to 100 %
        mag = (((acc < 0) ? -acc : acc) + ROUND_BIAS) >>> FRAC_DROP;
        if (mag > DRIVE_LIMIT) mag = DRIVE_LIMIT;
        cmd.drive = DRIVE_WIDTH'((acc < 0) ? -mag : mag);
        cmd.done_res = (mag <= SETTLE_LIMIT);
        cmd.timed_out = 1'b0;
        if (cmd.done_res) moving = 1'b0;
      end
      drive_cmds_due.push_back(cmd);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst) begin
      target = '0;
      err_limit = MAX_ERR_RESET;
      kp = '0;
      ki = '0;
      kd = '0;
      time_limit = '0;
      period = PERIOD_RESET;
      integ = 0;
      prev_err = 0;
      elapsed_ms = 0;
      moving = 1'b0;
      drive_cmds_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (sample_valid && !sample_stall) pid_step(position, start_req);
      if (result_valid && !result_stall) begin
        if (drive_cmds_due.size() == 0) begin
          $display("%0t unexpected item: drive %0d done_res %0b timed_out %0b",
                   $time, drive, done_res, timed_out);
          mismatches++;
        end else begin
          want = drive_cmds_due.pop_front();
          check_field("drive", int'(want.drive), int'(drive));
          check_field("done_res", int'(want.done_res), int'(done_res));
          check_field("timed_out", int'(want.timed_out), int'(timed_out));
        end
      end
    end
    pending <= drive_cmds_due.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/sv/pid_move_controller_tb.sv
`timescale 1ns / 1ps
// testbench top for pid_move_controller: directed and random moves, register
// settings and idling phases; depends on pmc_pkg, pmc_checker and the block
module pid_move_controller_tb;
  import pmc_pkg::*;

  localparam int LIMIT_CYCLES   = 600000;
  localparam int MOVES_PER_CFG  = 125;
  localparam int CFGS_PER_PHASE = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [DEF_SAMPLE_WIDTH-1:0] position = '0;
  logic start_req = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [DRIVE_WIDTH-1:0] drive;
  logic done_res;
  logic timed_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic signed [TARGET_WIDTH-1:0] target_now = '0;

  pid_move_controller DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .position(position), .start_req(start_req),
    .result_valid(result_valid), .result_stall(result_stall),
    .drive(drive), .done_res(done_res), .timed_out(timed_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pmc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) result_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic put_sample(input logic signed [DEF_SAMPLE_WIDTH-1:0] pos, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    position <= pos;
    start_req <= st;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // hold off until every drive command has come and the pipeline is empty
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                         input logic [CFG_DATA_WIDTH-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_WIDTH-1:0] tgt, input logic [CFG_DATA_WIDTH-1:0] me,
                          input logic [CFG_DATA_WIDTH-1:0] p, input logic [CFG_DATA_WIDTH-1:0] i,
                          input logic [CFG_DATA_WIDTH-1:0] d, input logic [CFG_DATA_WIDTH-1:0] tmo,
                          input logic [CFG_DATA_WIDTH-1:0] per);
    drain();
    put_reg(REG_TARGET, tgt);
    put_reg(REG_MAX_ERR, me);
    put_reg(REG_GAIN_P, p);
    put_reg(REG_GAIN_I, i);
    put_reg(REG_GAIN_D, d);
    put_reg(REG_TIMEOUT, tmo);
    put_reg(REG_PERIOD, per);
    // unused index must be ignored
    if ($urandom_range(2) == 0) put_reg(REG_UNUSED, CFG_DATA_WIDTH'($urandom));
    cfg_valid <= 1'b0;
    target_now = tgt[TARGET_WIDTH-1:0];
  endtask

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_gain();
    logic [CFG_DATA_WIDTH-1:0] g;
    case ($urandom_range(9))
      0: g = 17'h08000;
      1: g = 17'h07FFF;
      2: g = '0;
      3: g = CFG_DATA_WIDTH'($urandom);
      default: begin
        g = CFG_DATA_WIDTH'($urandom_range(0, 700));
        if ($urandom_range(3) == 0) g = -g;
      end
    endcase
    return g;
  endfunction

  task automatic random_regs();
    logic [CFG_DATA_WIDTH-1:0] tgt, me, tmo, per;
    logic [CFG_DATA_WIDTH-1:0] p, i, d;
    case ($urandom_range(5))
      0: tgt = 17'h08000;
      1: tgt = 17'h07FFF;
      default: tgt = CFG_DATA_WIDTH'($urandom);
    endcase
    case ($urandom_range(4))
      0: me = '0;
      1: me = MAX_ERR_RESET;
      2: me = CFG_DATA_WIDTH'($urandom);
      default: me = CFG_DATA_WIDTH'($urandom_range(0, 3000));
    endcase
    p = pick_gain();
    i = (pick_gain() >>> 3);
    d = pick_gain();
    case ($urandom_range(5))
      0: tmo = {1'($urandom), 16'hFFFF};
      1: tmo = CFG_DATA_WIDTH'($urandom);
      2: tmo = CFG_DATA_WIDTH'($urandom_range(1, 400));
      default: tmo = {1'($urandom), 16'h0000};
    endcase
    case ($urandom_range(5))
      0: per = '0;
      1: per = CFG_DATA_WIDTH'(1);
      2: per = CFG_DATA_WIDTH'(1000);
      3: per = CFG_DATA_WIDTH'($urandom);
      default: per = CFG_DATA_WIDTH'($urandom_range(1, 60));
    endcase
    set_regs(tgt, me, p, i, d, tmo, per);
  endtask

  // mostly well-formed moves that close in on the target, some noise items
  task automatic run_moves(input int n_items);
    int sent;
    int err;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        put_sample(DEF_SAMPLE_WIDTH'($urandom), ($urandom_range(5) == 0));
        sent++;
      end else begin
        if ($urandom_range(7) == 0) err = int'($urandom_range(0, 65535)) - 32768;
        else err = int'($urandom_range(0, 4000)) - 2000;
        put_sample(DEF_SAMPLE_WIDTH'(int'(target_now) - err), 1'b1);
        sent++;
        len = $urandom_range(1, 24);
        repeat (len) begin
          err = err - err / 4 + int'($urandom_range(0, 40)) - 20;
          put_sample(DEF_SAMPLE_WIDTH'(int'(target_now) - err), 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_stall_pct = 67;

    // reset values: zero gains settle on the first update, idle sample ignored
    put_sample(16'sd0, 1'b1);
    put_sample(16'sd100, 1'b0);
    put_sample(16'sd5, 1'b0);

    // full scale errors saturate the drive both ways, zero error settles
    set_regs(17'h00000, MAX_ERR_RESET, 17'h07FFF, 17'h00010, 17'h00000, 17'h00000, 17'd15);
    put_sample(16'sd0, 1'b1);
    put_sample(-16'sd32768, 1'b0);
    put_sample(16'sd32767, 1'b0);
    put_sample(16'sd0, 1'b0);

    // extreme negative p and d gains, integral always cleared, restart in mid move
    set_regs(17'h07FFF, 17'h00000, 17'h18000, 17'h07FFF, 17'h18000, 17'h00000, 17'd15);
    put_sample(-16'sd32768, 1'b1);
    put_sample(-16'sd32768, 1'b0);
    put_sample(16'sd100, 1'b1);
    put_sample(16'sd32767, 1'b0);
    put_sample(16'sd32000, 1'b0);

    // time limit passes on the third update
    set_regs(17'h00000, 17'd1000, 17'h00100, 17'h00000, 17'h00000, 17'd30, 17'd15);
    put_sample(-16'sd2000, 1'b1);
    put_sample(-16'sd2000, 1'b0);
    put_sample(-16'sd2000, 1'b0);
    put_sample(-16'sd2000, 1'b0);

    // zero period never reaches the limit
    set_regs(17'h00000, 17'd1000, 17'h00100, 17'h00020, 17'h00040, 17'd1, 17'd0);
    put_sample(-16'sd2000, 1'b1);
    put_sample(-16'sd2000, 1'b0);
    put_sample(-16'sd1800, 1'b0);
    put_sample(-16'sd1500, 1'b0);
    put_sample(16'sd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_stall_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int k = 0; k < CFGS_PER_PHASE; k++) begin
        random_regs();
        run_moves(MOVES_PER_CFG);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pmc_pkg.sv
design/pmc_cfg_regs.sv
design/pmc_core.sv
design/pid_move_controller.sv
tb/sv/pmc_checker.sv
tb/sv/pid_move_controller_tb.sv
